### hw/rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the symbol lookup shared by the base64 encoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

  localparam int unsigned NUM_WORDS   = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned SYMBOLS     = 64;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned QUAD        = 4;

  localparam logic [7:0] PAD_SYMBOL     = 8'h3D;
  localparam logic [5:0] SIX_BITS       = 6'b111111;
  localparam int unsigned GROUP_TOP_SHIFT = 18;

  // symbol k at bits 8k+7..8k, i.e. byte k mod 8 of word k/8
  typedef logic [SYMBOLS-1:0][BYTE_W-1:0] alphabet_t;

  typedef struct packed {
    logic [QUAD-1:0][BYTE_W-1:0] symbols;  // symbols[0] goes out first
    logic                        last;
  } quad_t;

  function automatic logic [BYTE_W-1:0] symbol_at(alphabet_t alpha, logic [5:0] idx);
    symbol_at = alpha[idx];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/b64e_alphabet.sv
// ----------------------------------------------------------------------------
// b64e_alphabet
// Alphabet register file, eight 64-bit words written through a plain port.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_alphabet (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [b64e_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [b64e_pkg::WORD_W-1:0]      wr_data,
  output b64e_pkg::alphabet_t                   alphabet
);

  b64e_pkg::alphabet_t regs;
  logic [5:0]          base;

  assign base     = {wr_index[2:0], 3'b000};
  assign alphabet = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (wr_en && !wr_index[b64e_pkg::CFG_INDEX_W-1]) begin
      // indexes of 8 and up are dropped
      regs[base +: 8] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/b64e_group.sv
// ----------------------------------------------------------------------------
// b64e_group
// Pending byte buffer and group formation with alphabet lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_group (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [b64e_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                        end_of_message,
  input  wire b64e_pkg::alphabet_t         alphabet,
  output logic                             fire,
  output b64e_pkg::quad_t                  quad
);

  logic [15:0] pending_bytes;
  logic [1:0]  pending_count;
  logic [23:0] group;
  logic [2:0]  real_count;
  logic [5:0]  idx;
  logic [23:0] shifted;

  assign fire = end_of_message || (pending_count == 2'd2);

  always_comb begin
    unique case (pending_count)
      2'd2:    group = {pending_bytes, data_byte};
      2'd1:    group = {pending_bytes[7:0], data_byte, 8'h00};
      default: group = {data_byte, 16'h0000};
    endcase
    real_count = 3'(pending_count) + 3'd2;
  end

  always_comb begin
    shifted = '0;
    idx     = '0;
    for (int k = 0; k < b64e_pkg::QUAD; k++) begin
      shifted = group >> (b64e_pkg::GROUP_TOP_SHIFT - 6 * k);
      idx     = shifted[5:0] & b64e_pkg::SIX_BITS;
      if (3'(k) < real_count) begin
        quad.symbols[k] = b64e_pkg::symbol_at(alphabet, idx);
      end else begin
        quad.symbols[k] = b64e_pkg::PAD_SYMBOL;
      end
    end
    quad.last = end_of_message;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bytes <= '0;
      pending_count <= '0;
    end else if (accept) begin
      if (fire) begin
        pending_bytes <= '0;
        pending_count <= '0;
      end else begin
        pending_bytes <= {pending_bytes[7:0], data_byte};
        pending_count <= pending_count + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/b64e_serializer.sv
// ----------------------------------------------------------------------------
// b64e_serializer
// Result register holding four symbols, shifted out one word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_serializer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire b64e_pkg::quad_t              quad,
  output logic                              can_load,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [b64e_pkg::BYTE_W-1:0]       m_tdata,
  output logic                              m_tlast
);

  logic [b64e_pkg::QUAD-1:0][b64e_pkg::BYTE_W-1:0] sym;
  logic [b64e_pkg::QUAD-1:0]                       vld;
  logic [b64e_pkg::QUAD-1:0]                       lastv;
  logic                                            take;

  assign m_tvalid = vld[0];
  assign m_tdata  = sym[0];
  assign m_tlast  = lastv[0];
  assign take     = m_tvalid && m_tready;
  // empty, or the final held word leaves this cycle
  assign can_load = !vld[0] || (m_tready && !vld[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      lastv <= '0;
    end else if (load) begin
      vld   <= '1;
      lastv <= {quad.last, 3'b000};
    end else if (take) begin
      vld   <= {1'b0, vld[b64e_pkg::QUAD-1:1]};
      lastv <= {1'b0, lastv[b64e_pkg::QUAD-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sym <= quad.symbols;
    end else if (take) begin
      sym <= {8'h00, sym[b64e_pkg::QUAD-1:1]};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/custom_alphabet_base64_encoder.sv
// ----------------------------------------------------------------------------
// custom_alphabet_base64_encoder
// Base64 encoder with a software-programmed 64-symbol alphabet.
// ----------------------------------------------------------------------------
// Raw bytes arrive one word per handshake on the slave side, tlast marking the
// final byte of a message. Bytes that neither complete a group nor end the
// message are taken every cycle and only buffered. A byte that completes a
// group of three, or ends the message, is looked up in the alphabet in the same
// cycle and loaded into a four-symbol result register, which then sends one
// symbol per cycle while m_tready is high; short final groups are padded with
// '='. The result register sets the rate of a steady stream, and a new group is
// taken in the cycle its predecessor's last symbol leaves. Program the alphabet
// while the block idles.
// ----------------------------------------------------------------------------
`default_nettype none

module custom_alphabet_base64_encoder (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [b64e_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [b64e_pkg::WORD_W-1:0]      wr_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,   // data_byte
  input  wire logic                             s_tlast,   // end_of_message
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [7:0]                            m_tdata,   // out_symbol
  output logic                                  m_tlast    // last_symbol
);

  b64e_pkg::alphabet_t alphabet;
  b64e_pkg::quad_t     quad;
  logic                fire;
  logic                can_load;
  logic                accept;

  assign s_tready = !fire || can_load;
  assign accept   = s_tvalid && s_tready;

  b64e_alphabet u_alphabet (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .alphabet (alphabet)
  );

  b64e_group u_group (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (s_tdata),
    .end_of_message (s_tlast),
    .alphabet       (alphabet),
    .fire           (fire),
    .quad           (quad)
  );

  b64e_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && fire),
    .quad     (quad),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

### hw/rtl/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks for the base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       s_tlast,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // a message end always leaves symbols in the result register
  a_end_loads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("end of message gave no output");

  // input only stalls behind pending results
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with nothing to send");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind custom_alphabet_base64_encoder b64e_checker u_b64e_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
